@@ sv/tqls_pkg.sv @@
package tqls_pkg;

   // Field widths
   localparam int Q_W        = 4;
   localparam int HEADING_W  = 2;
   localparam int REWARD_W   = 9;
   localparam int PCT_W      = 7;
   localparam int RMOVE_W    = 2;
   localparam int LSTATE_W   = 6;
   localparam int LMOVE_W    = 2;
   localparam int STATE_W    = 6;
   localparam int MOVE_W     = 2;
   localparam int HIST_W     = 6;
   localparam int RATE_W     = 9;

   // State index lookup covers every history code
   localparam int ROW_TAB_DEPTH = 2 ** HIST_W;

   // Update arithmetic widths
   localparam int INNER_W = 15;
   localparam int PROD_W  = 24;
   localparam int T_W     = 25;
   localparam int FRAC_W  = 16;
   localparam int V_W     = T_W - FRAC_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPLORE_PERCENT = 2'd2;

   localparam logic [RATE_W-1:0] LEARNING_RATE_RESET   = 9'd26;
   localparam logic [RATE_W-1:0] DISCOUNT_FACTOR_RESET = 9'd230;
   localparam logic [PCT_W-1:0]  EXPLORE_PERCENT_RESET = 7'd10;

   localparam logic signed [Q_W-1:0] Q_MAX = 4'sd7;
   localparam logic signed [Q_W-1:0] Q_MIN = -4'sd7;

   localparam logic [1:0] WARM_DONE = 2'd3;

   localparam logic ITEM_LOAD = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_MULT,
      ST_FINAL
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic calc_en;
      logic mult_en;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                       action;
      logic [HEADING_W-1:0]       heading_quadrant;
      logic [REWARD_W-1:0]        reward_scaled;
      logic [PCT_W-1:0]           random_percent;
      logic [RMOVE_W-1:0]         random_move;
      logic [LSTATE_W-1:0]        load_state;
      logic [LMOVE_W-1:0]         load_move;
      logic signed [Q_W-1:0]      load_value;
   } step_req_type;

   typedef struct packed {
      logic                       step_valid;
      logic [STATE_W-1:0]         state_index;
      logic [MOVE_W-1:0]          chosen_move;
      logic                       explored;
      logic signed [Q_W-1:0]      updated_q;
   } step_rsp_type;

endpackage

@@ sv/tqls_if.sv @@
interface step_req_if;
   logic                   valid;
   logic                   ready;
   tqls_pkg::step_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface step_rsp_if;
   logic                   valid;
   logic                   ready;
   tqls_pkg::step_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface csr_if;
   logic                                valid;
   logic                                ready;
   logic [tqls_pkg::CSR_IDX_W-1:0]      index;
   logic [tqls_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/tabular_q_learning_step_unit.sv @@
// Flow: an item's table rows are read as it is accepted, then the inner sum and the
// product are registered in turn, then truncate/saturate/choose/write happen in the
// commit state, which waits while the output is stalled. The read-update-write chain on
// the table's two read ports and one write port is held by a single item at a time.
// Reset: controller idle, registers to defaults, history/warm-up/previous cleared,
// every table row marked unwritten so it reads as zero; no clearing pass.
module tabular_q_learning_step_unit #(
   parameter int STATE_COUNT = 64,
   parameter int MOVE_COUNT  = 3
) (
   input logic          clock,
   input logic          reset,
   step_req_if.sink     req_chan,
   step_rsp_if.source   rsp_chan,
   csr_if.sink          csr_chan
);
   import tqls_pkg::*;

   ctrl_cmd_type cmd;
   logic         req_ready;
   logic         rsp_valid;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   tqls_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   tqls_datapath #(
      .STATE_COUNT (STATE_COUNT),
      .MOVE_COUNT  (MOVE_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_chan.payload),
      .csr_write   (csr_chan.valid),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

@@ sv/tqls_controller.sv @@
module tqls_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tqls_pkg::ctrl_cmd_type cmd
);
   import tqls_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc_en = 1'b1;
            state_in    = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult_en = 1'b1;
            state_in    = ST_FINAL;
         end
         ST_FINAL: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

@@ sv/tqls_datapath.sv @@
module tqls_datapath #(
   parameter int STATE_COUNT = 64,
   parameter int MOVE_COUNT  = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tqls_pkg::ctrl_cmd_type            cmd,
   input  tqls_pkg::step_req_type            req_payload,
   input  logic                              csr_write,
   input  logic [tqls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tqls_pkg::CSR_DATA_W-1:0]   csr_data,
   output tqls_pkg::step_rsp_type            rsp_payload
);
   import tqls_pkg::*;

   localparam int IDX_W = $clog2(STATE_COUNT);
   localparam int MV_W  = (MOVE_COUNT > 1) ? $clog2(MOVE_COUNT) : 1;
   localparam int ROW_W = MOVE_COUNT * Q_W;

   function automatic logic signed [Q_W-1:0] col_of(input logic [ROW_W-1:0] row,
                                                    input logic [MV_W-1:0]  k);
      return $signed(row[k*Q_W +: Q_W]);
   endfunction

   function automatic logic [ROW_W-1:0] put_col(input logic [ROW_W-1:0]      row,
                                                input logic [MV_W-1:0]       k,
                                                input logic signed [Q_W-1:0] v);
      logic [ROW_W-1:0] r;
      r = row;
      r[k*Q_W +: Q_W] = v;
      return r;
   endfunction

   // ties go to the lowest move
   function automatic logic [MV_W-1:0] best_of(input logic [ROW_W-1:0] row);
      logic [MV_W-1:0]       best;
      logic signed [Q_W-1:0] bv;
      best = '0;
      bv   = $signed(row[Q_W-1:0]);
      for (int k = 1; k < MOVE_COUNT; k++) begin
         if ($signed(row[k*Q_W +: Q_W]) > bv) begin
            bv   = $signed(row[k*Q_W +: Q_W]);
            best = MV_W'(k);
         end
      end
      return best;
   endfunction

   // history code to table row
   logic [IDX_W-1:0] row_tab [ROW_TAB_DEPTH];
   for (genvar i = 0; i < ROW_TAB_DEPTH; i++) begin : g_row_tab
      assign row_tab[i] = IDX_W'(i % STATE_COUNT);
   end

   // configuration
   logic [RATE_W-1:0] lr_ff, df_ff;
   logic [PCT_W-1:0]  ex_ff;

   // learning state
   logic [HIST_W-1:0]      hist_ff;
   logic [1:0]             warm_ff;
   logic [IDX_W-1:0]       prev_state_ff;
   logic [MV_W-1:0]        prev_move_ff;
   logic [STATE_COUNT-1:0] row_vld_ff;

   // Q table
   logic [ROW_W-1:0] q_mem [STATE_COUNT];
   logic [ROW_W-1:0] rd_a_ff, rd_b_ff;
   logic             vld_a_ff, vld_b_ff;
   logic [IDX_W-1:0] addr_a_ff, addr_b_ff;

   step_req_type item_ff;
   step_rsp_type rsp_ff, rsp_in;

   logic signed [INNER_W-1:0] inner_ff, inner_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   logic [HIST_W-1:0]      hist_accept, hist_next;
   logic [IDX_W-1:0]       addr_a_in, addr_b_in;
   logic [ROW_W-1:0]       row_a, row_b, row_choice;
   logic signed [Q_W-1:0]  q_old, max_q, new_q, load_val;
   logic [REWARD_W+3:0]    reward10;
   logic signed [13:0]     gm;
   logic signed [T_W-1:0]  t_sum;
   logic signed [V_W-1:0]  v_trunc;
   logic                   round_up, explore, warm, load_ok;
   logic [MV_W-1:0]        rmove_sat, move, load_col;
   logic                   wr_en;
   logic [ROW_W-1:0]       wr_data;

   assign hist_accept = {req_payload.heading_quadrant, hist_ff[HIST_W-1:HEADING_W]};
   assign hist_next   = {item_ff.heading_quadrant, hist_ff[HIST_W-1:HEADING_W]};
   assign addr_a_in   = (req_payload.action == ITEM_LOAD) ? row_tab[req_payload.load_state]
                                                          : prev_state_ff;
   assign addr_b_in   = row_tab[hist_accept];

   // rows never written read as zero
   assign row_a = vld_a_ff ? rd_a_ff : '0;
   assign row_b = vld_b_ff ? rd_b_ff : '0;

   assign q_old = col_of(row_a, prev_move_ff);
   assign max_q = col_of(row_b, best_of(row_b));

   // inner = 10*r + g*m - 256*q
   assign reward10 = {1'b0, item_ff.reward_scaled, 3'b000}
                   + {3'b000, item_ff.reward_scaled, 1'b0};
   assign gm       = $signed({1'b0, df_ff}) * max_q;
   assign inner_in = INNER_W'($signed({1'b0, reward10}))
                   + INNER_W'(gm)
                   - (INNER_W'(q_old) <<< 8);

   assign prod_in = $signed({1'b0, lr_ff}) * inner_ff;

   // truncate toward zero, then saturate
   assign t_sum    = (T_W'(q_old) <<< FRAC_W) + T_W'(prod_ff);
   assign round_up = t_sum[T_W-1] && (t_sum[FRAC_W-1:0] != '0);
   assign v_trunc  = t_sum[T_W-1:FRAC_W] + $signed({{(V_W-1){1'b0}}, round_up});

   always_comb begin
      if (v_trunc > Q_MAX) begin
         new_q = Q_MAX;
      end else if (v_trunc < Q_MIN) begin
         new_q = Q_MIN;
      end else begin
         new_q = v_trunc[Q_W-1:0];
      end
   end

   // choice sees the fresh value when previous and current rows coincide
   assign row_choice = (addr_a_ff == addr_b_ff) ? put_col(row_b, prev_move_ff, new_q) : row_b;
   assign explore    = item_ff.random_percent < ex_ff;
   assign rmove_sat  = (32'(item_ff.random_move) < 32'(MOVE_COUNT)) ? MV_W'(item_ff.random_move)
                                                                    : MV_W'(MOVE_COUNT - 1);
   assign move       = explore ? rmove_sat : best_of(row_choice);
   assign warm       = (warm_ff == WARM_DONE);

   assign load_ok  = 32'(item_ff.load_move) < 32'(MOVE_COUNT);
   assign load_col = MV_W'(item_ff.load_move);
   assign load_val = (item_ff.load_value < Q_MIN) ? Q_MIN : item_ff.load_value;

   always_comb begin
      wr_en   = 1'b0;
      wr_data = row_a;
      rsp_in  = '0;
      if (item_ff.action == ITEM_LOAD) begin
         if (load_ok) begin
            wr_en   = cmd.commit;
            wr_data = put_col(row_a, load_col, load_val);
         end
      end else begin
         rsp_in.state_index = STATE_W'(addr_b_ff);
         if (warm) begin
            wr_en              = cmd.commit;
            wr_data            = put_col(row_a, prev_move_ff, new_q);
            rsp_in.step_valid  = 1'b1;
            rsp_in.chosen_move = MOVE_W'(move);
            rsp_in.explored    = explore;
            rsp_in.updated_q   = new_q;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff         <= LEARNING_RATE_RESET;
         df_ff         <= DISCOUNT_FACTOR_RESET;
         ex_ff         <= EXPLORE_PERCENT_RESET;
         hist_ff       <= '0;
         warm_ff       <= '0;
         prev_state_ff <= '0;
         prev_move_ff  <= '0;
         row_vld_ff    <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LEARNING_RATE:   lr_ff <= csr_data;
               CSR_DISCOUNT_FACTOR: df_ff <= csr_data;
               CSR_EXPLORE_PERCENT: ex_ff <= csr_data[PCT_W-1:0];
               default: ;
            endcase
         end
         if (wr_en) begin
            row_vld_ff[addr_a_ff] <= 1'b1;
         end
         if (cmd.commit && item_ff.action != ITEM_LOAD) begin
            hist_ff       <= hist_next;
            prev_state_ff <= addr_b_ff;
            if (warm) begin
               prev_move_ff <= move;
            end else begin
               warm_ff <= warm_ff + 2'd1;
            end
         end
      end
   end

   // payload and table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_mem[addr_a_ff] <= wr_data;
      end
      if (cmd.accept) begin
         item_ff   <= req_payload;
         addr_a_ff <= addr_a_in;
         addr_b_ff <= addr_b_in;
         rd_a_ff   <= q_mem[addr_a_in];
         rd_b_ff   <= q_mem[addr_b_in];
         vld_a_ff  <= row_vld_ff[addr_a_in];
         vld_b_ff  <= row_vld_ff[addr_b_in];
      end
      if (cmd.calc_en) begin
         inner_ff <= inner_in;
      end
      if (cmd.mult_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

@@ sv/tqls_checker.sv @@
module tqls_checker #(
   parameter int MOVE_COUNT = 3
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input tqls_pkg::step_rsp_type rsp_payload
);
   import tqls_pkg::*;

   // result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is at work");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.step_valid |->
         rsp_payload.chosen_move == '0 && !rsp_payload.explored &&
         rsp_payload.updated_q == '0)
      else $error("non-step result carries move or update");

   a_q_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.updated_q >= Q_MIN)
      else $error("updated value below saturation limit");

   a_move_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.step_valid |-> 32'(rsp_payload.chosen_move) < 32'(MOVE_COUNT))
      else $error("chosen move out of range");

endmodule

bind tabular_q_learning_step_unit tqls_checker #(
   .MOVE_COUNT (MOVE_COUNT)
) u_tqls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
